FILE: sv/pixel_store_bilinear_sampler_macros.svh
// ----------------------------------------------------------------------------
// Pixel store sampler assertion macros
// Shared assertion forms for the checker of the pixel store sampler.
// ----------------------------------------------------------------------------
`ifndef PIXEL_STORE_BILINEAR_SAMPLER_MACROS_SVH
`define PIXEL_STORE_BILINEAR_SAMPLER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PSBS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define PSBS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/psbs_pkg.sv
// ----------------------------------------------------------------------------
// Pixel store sampler package
// Widths, codes and payload types shared by the sampler modules.
// ----------------------------------------------------------------------------
package psbs_pkg;

    // Store geometry (depth is a power of two: addresses wrap by truncation)
    localparam int STORE_DEPTH  = 262144;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    // Field widths
    localparam int REQ_W        = 2;
    localparam int COORD_W      = 10;
    localparam int DIM_W        = 10;
    localparam int PIX_W        = 8;
    localparam int FIELD_FRAC_W = 16;
    localparam int BASE_W       = COORD_W + DIM_W;

    // Interpolation arithmetic
    localparam int FRAC_BITS    = 16;
    localparam int DIFF_W       = PIX_W + 1;
    localparam int PROD_W       = DIFF_W + FRAC_BITS + 1;
    localparam int STEP_W       = PROD_W - FRAC_BITS;
    localparam int NBR_TAPS     = 4;
    localparam int TAP_CNT_W    = $clog2(NBR_TAPS);

    // Queue depths
    localparam int CMDQ_DEPTH   = 2;
    localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);
    localparam int RSPQ_DEPTH   = 2;
    localparam int RSPQ_PTR_W   = $clog2(RSPQ_DEPTH);
    localparam int RSPQ_CNT_W   = $clog2(RSPQ_DEPTH + 1);

    // Configuration registers
    localparam int CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;
    localparam logic [DIM_W-1:0]     DIM_RESET        = 10'd256;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FILTER = 2'd2;

    typedef enum logic [2:0] {
        K_WRITE,
        K_READ,
        K_FILTER,
        K_OOB,
        K_NONE
    } t_kind;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [COORD_W-1:0]      x_int;
        logic [COORD_W-1:0]      y_int;
        logic [FIELD_FRAC_W-1:0] x_frac;
        logic [FIELD_FRAC_W-1:0] y_frac;
        logic [PIX_W-1:0]        pixel_value;
    } t_req;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             out_of_bounds;
    } t_rsp;

    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } t_cfg;

    typedef struct packed {
        t_kind                kind;
        logic [ADDR_W-1:0]    addr;
        logic [DIM_W-1:0]     stride;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic [PIX_W-1:0]     pix;
    } t_cmd;

endpackage

FILE: sv/pixel_store_bilinear_sampler.sv
// A write, an out-of-bounds or an unused request goes from idle straight to the done
// state, a read passes through the read state, and a filtered read through the fetch,
// multiply and sum states; each result can be popped once it is in the result queue.
// The back-end sequencer handles one request at a time over the single store port;
// further requests wait in the request queue meanwhile.
// Reset clears the queues and the sequencer and sets width and height to 256.
// ----------------------------------------------------------------------------
// Pixel store with bilinear sampler
// 8-bit pixel store with point write, point read and filtered 2x2 read.
// ----------------------------------------------------------------------------
module pixel_store_bilinear_sampler
    import psbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request queue side
    input  logic                 push,
    output logic                 full,
    input  t_req                 i_req,
    // Result queue side
    output logic                 empty,
    input  logic                 pop,
    output t_rsp                 o_rsp,
    // Configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    // The pixel store itself holds no reset value.
    t_cfg r_cfg;
    t_cmd w_front_cmd;
    t_cmd w_back_cmd;
    logic w_cmd_push;
    logic w_q_full;
    logic w_q_empty;
    logic w_q_pop;

    // Configuration registers: always ready, one transfer per cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= DIM_RESET;
            r_cfg.image_height <= DIM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: form x + width * y, check bounds, tag the request kind.
    psbs_front u_front (
        .i_push     (push),
        .i_q_full   (w_q_full),
        .i_req      (i_req),
        .i_cfg      (r_cfg),
        .o_full     (full),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_front_cmd)
    );

    // Decouple front and back so either side can stall on its own.
    psbs_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_cmd   (w_back_cmd),
        .o_empty (w_q_empty)
    );

    // Back end: one command at a time. Writes and reads take the store port
    // once; a filtered read fetches its four neighbors in turn, then
    // runs two vertical lerps and one horizontal lerp, each as a multiply
    // stage followed by a shift-and-add stage. Results wait in a small queue
    // so the sequencer keeps going while the consumer stalls, until that queue is full.
    psbs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_back_cmd),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_rsp     (o_rsp)
    );

endmodule

FILE: sv/psbs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module psbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/psbs_front.sv
// ----------------------------------------------------------------------------
// Sampler front end
// Accept requests, form the linear address and classify each request.
// ----------------------------------------------------------------------------
module psbs_front
    import psbs_pkg::*;
(
    input  logic i_push,
    input  logic i_q_full,
    input  t_req i_req,
    input  t_cfg i_cfg,
    output logic o_full,
    output logic o_cmd_push,
    output t_cmd o_cmd
);

    logic [BASE_W-1:0] w_base;
    logic              w_oob;
    t_kind             w_kind;

    assign w_base = BASE_W'(i_req.x_int) + i_cfg.image_width * i_req.y_int;
    assign w_oob  = (i_req.x_int >= i_cfg.image_width) ||
                    (i_req.y_int >= i_cfg.image_height);

    always_comb begin
        case (i_req.req_type)
            REQ_WRITE:  w_kind = w_oob ? K_OOB : K_WRITE;
            REQ_READ:   w_kind = w_oob ? K_OOB : K_READ;
            REQ_FILTER: w_kind = K_FILTER;
            default:    w_kind = K_NONE;
        endcase
    end

    assign o_cmd.kind   = w_kind;
    assign o_cmd.addr   = w_base[ADDR_W-1:0];
    assign o_cmd.stride = i_cfg.image_width;
    // Take the top FRAC_BITS of the fraction field; both are 16 bits, so none are dropped.
    assign o_cmd.fx     = i_req.x_frac[FIELD_FRAC_W-1 -: FRAC_BITS];
    assign o_cmd.fy     = i_req.y_frac[FIELD_FRAC_W-1 -: FRAC_BITS];
    assign o_cmd.pix    = i_req.pixel_value;

    assign o_full     = i_q_full;
    assign o_cmd_push = i_push && !i_q_full;

endmodule

FILE: sv/psbs_cmd_queue.sv
// ----------------------------------------------------------------------------
// Sampler command queue
// Short queue of classified commands between front end and back end.
// ----------------------------------------------------------------------------
module psbs_cmd_queue
    import psbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd                  r_data [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wptr, n_wptr;
    logic [CMDQ_PTR_W-1:0] r_rptr, n_rptr;
    logic [CMDQ_CNT_W-1:0] r_cnt, n_cnt;
    logic                  w_push, w_pop;

    assign o_full  = (r_cnt == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_cmd   = r_data[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_push) begin
            n_wptr = (r_wptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wptr] <= i_cmd;
        end
    end

endmodule

FILE: sv/psbs_back.sv
// ----------------------------------------------------------------------------
// Sampler back end
// Sequence store accesses and interpolation, and queue the results.
// ----------------------------------------------------------------------------
module psbs_back
    import psbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_q_empty,
    output logic o_q_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_rsp o_rsp
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_READ  = 8'b0000_0010,
        ST_FETCH = 8'b0000_0100,
        ST_MULV  = 8'b0000_1000,
        ST_SUMV  = 8'b0001_0000,
        ST_MULH  = 8'b0010_0000,
        ST_SUMH  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } t_state;

    t_state                       r_state, n_state;
    t_cmd                         r_cmd, n_cmd;
    logic [TAP_CNT_W-1:0]         r_cnt, n_cnt;
    t_rsp                         r_res, n_res;
    logic [PIX_W-1:0]             r_pix [NBR_TAPS];
    logic [PIX_W-1:0]             n_pix [NBR_TAPS];
    logic signed [PROD_W-1:0]     r_prod_a, n_prod_a;
    logic signed [PROD_W-1:0]     r_prod_b, n_prod_b;
    logic [PIX_W-1:0]             r_a, n_a;
    logic [PIX_W-1:0]             r_b, n_b;

    logic                         w_ram_we;
    logic [ADDR_W-1:0]            w_ram_addr;
    logic [PIX_W-1:0]             w_ram_rdata;
    logic [ADDR_W-1:0]            w_stride;

    logic signed [DIFF_W-1:0]     w_diff_va, w_diff_vb, w_diff_h, w_mul_d;
    logic [FRAC_BITS-1:0]         w_mul_f;
    logic signed [FRAC_BITS:0]    w_mul_fs, w_fy_s;
    logic signed [PROD_W-1:0]     w_mul_a, w_mul_b;
    logic [PIX_W-1:0]             w_sum_base;
    logic [STEP_W-1:0]            w_sum_a, w_sum_b;

    t_rsp                         r_rq_data [RSPQ_DEPTH];
    logic [RSPQ_PTR_W-1:0]        r_rq_wptr, n_rq_wptr;
    logic [RSPQ_PTR_W-1:0]        r_rq_rptr, n_rq_rptr;
    logic [RSPQ_CNT_W-1:0]        r_rq_cnt, n_rq_cnt;
    logic                         w_rq_full, w_rq_push, w_rq_pop;

    psbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (i_cmd.pix),
        .o_rdata (w_ram_rdata)
    );

    assign w_stride = ADDR_W'(r_cmd.stride);

    // Differences for the vertical pair and the horizontal step.
    assign w_diff_va = DIFF_W'({1'b0, r_pix[2]}) - DIFF_W'({1'b0, r_pix[0]});
    assign w_diff_vb = DIFF_W'({1'b0, r_pix[3]}) - DIFF_W'({1'b0, r_pix[1]});
    assign w_diff_h  = DIFF_W'({1'b0, r_b}) - DIFF_W'({1'b0, r_a});

    // Shared multiplier A serves the first vertical lerp and the horizontal one.
    assign w_mul_d  = (r_state == ST_MULH) ? w_diff_h : w_diff_va;
    assign w_mul_f  = (r_state == ST_MULH) ? r_cmd.fx : r_cmd.fy;
    assign w_mul_fs = {1'b0, w_mul_f};
    assign w_fy_s   = {1'b0, r_cmd.fy};
    assign w_mul_a  = w_mul_d * w_mul_fs;
    assign w_mul_b  = w_diff_vb * w_fy_s;

    // Arithmetic shift of the product gives the floor of the scaled step.
    assign w_sum_base = (r_state == ST_SUMH) ? r_a : r_pix[0];
    assign w_sum_a    = STEP_W'(w_sum_base) + r_prod_a[PROD_W-1:FRAC_BITS];
    assign w_sum_b    = STEP_W'(r_pix[1]) + r_prod_b[PROD_W-1:FRAC_BITS];

    assign w_rq_full = (r_rq_cnt == RSPQ_CNT_W'(RSPQ_DEPTH));
    assign o_empty   = (r_rq_cnt == '0);
    assign w_rq_pop  = i_pop && !o_empty;
    assign o_rsp     = r_rq_data[r_rq_rptr];

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_cnt      = r_cnt;
        n_res      = r_res;
        n_prod_a   = r_prod_a;
        n_prod_b   = r_prod_b;
        n_a        = r_a;
        n_b        = r_b;
        for (int i = 0; i < NBR_TAPS; i++) begin
            n_pix[i] = r_pix[i];
        end
        o_q_pop    = 1'b0;
        w_ram_we   = 1'b0;
        w_ram_addr = i_cmd.addr;
        w_rq_push  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_cmd;
                    n_res   = '0;
                    case (i_cmd.kind)
                        K_WRITE: begin
                            w_ram_we = 1'b1;
                            n_state  = ST_DONE;
                        end
                        K_READ: begin
                            n_state = ST_READ;
                        end
                        K_FILTER: begin
                            n_cnt   = '0;
                            n_state = ST_FETCH;
                        end
                        K_OOB: begin
                            n_res.out_of_bounds = 1'b1;
                            n_state             = ST_DONE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_res.pixel_out = w_ram_rdata;
                n_state         = ST_DONE;
            end
            ST_FETCH: begin
                // Shift in the neighbor read last cycle, issue the next one.
                for (int i = 0; i < NBR_TAPS - 1; i++) begin
                    n_pix[i] = r_pix[i + 1];
                end
                n_pix[NBR_TAPS-1] = w_ram_rdata;
                case (r_cnt)
                    2'd0:    w_ram_addr = r_cmd.addr + 1'b1;
                    2'd1:    w_ram_addr = r_cmd.addr + w_stride;
                    2'd2:    w_ram_addr = r_cmd.addr + w_stride + 1'b1;
                    default: w_ram_addr = r_cmd.addr;
                endcase
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == TAP_CNT_W'(NBR_TAPS - 1)) begin
                    n_state = ST_MULV;
                end
            end
            ST_MULV: begin
                n_prod_a = w_mul_a;
                n_prod_b = w_mul_b;
                n_state  = ST_SUMV;
            end
            ST_SUMV: begin
                n_a     = w_sum_a[PIX_W-1:0];
                n_b     = w_sum_b[PIX_W-1:0];
                n_state = ST_MULH;
            end
            ST_MULH: begin
                n_prod_a = w_mul_a;
                n_state  = ST_SUMH;
            end
            ST_SUMH: begin
                n_res.pixel_out = w_sum_a[PIX_W-1:0];
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                if (!w_rq_full) begin
                    w_rq_push = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_rq_wptr = r_rq_wptr;
        n_rq_rptr = r_rq_rptr;
        n_rq_cnt  = r_rq_cnt;
        if (w_rq_push) begin
            n_rq_wptr = (r_rq_wptr == RSPQ_PTR_W'(RSPQ_DEPTH - 1)) ? '0 : r_rq_wptr + 1'b1;
        end
        if (w_rq_pop) begin
            n_rq_rptr = (r_rq_rptr == RSPQ_PTR_W'(RSPQ_DEPTH - 1)) ? '0 : r_rq_rptr + 1'b1;
        end
        if (w_rq_push && !w_rq_pop) begin
            n_rq_cnt = r_rq_cnt + 1'b1;
        end else if (w_rq_pop && !w_rq_push) begin
            n_rq_cnt = r_rq_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rq_wptr <= '0;
            r_rq_rptr <= '0;
            r_rq_cnt  <= '0;
        end else begin
            r_state   <= n_state;
            r_rq_wptr <= n_rq_wptr;
            r_rq_rptr <= n_rq_rptr;
            r_rq_cnt  <= n_rq_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
        r_prod_a <= n_prod_a;
        r_prod_b <= n_prod_b;
        r_a      <= n_a;
        r_b      <= n_b;
        for (int i = 0; i < NBR_TAPS; i++) begin
            r_pix[i] <= n_pix[i];
        end
        if (w_rq_push) begin
            r_rq_data[r_rq_wptr] <= r_res;
        end
    end

endmodule

FILE: sv/psbs_checker.sv
// ----------------------------------------------------------------------------
// Pixel store sampler checker
// Port-level assertions, bound to the sampler top level.
// ----------------------------------------------------------------------------
`include "pixel_store_bilinear_sampler_macros.svh"

module psbs_checker
    import psbs_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic push,
    input logic full,
    input logic empty,
    input logic pop,
    input t_rsp o_rsp
);

    // Both queues come out of reset drained.
    `PSBS_ASSERT_ALWAYS(a_reset_drained, i_clk, !i_rst_n |=> empty && !full, "queues not drained after reset")

    // Only a push can fill the request side.
    `PSBS_ASSERT(a_full_needs_push, i_clk, i_rst_n, !full && !push |=> !full, "full rose without a push")

    // An out-of-bounds access never carries pixel data.
    `PSBS_ASSERT(a_oob_zero, i_clk, i_rst_n, !empty && o_rsp.out_of_bounds |-> o_rsp.pixel_out == '0, "out-of-bounds result with nonzero pixel")

    // A result not taken stays in place.
    `PSBS_ASSERT(a_rsp_hold, i_clk, i_rst_n, !empty && !pop |=> !empty && $stable(o_rsp), "waiting result changed or vanished")

endmodule

bind pixel_store_bilinear_sampler psbs_checker u_psbs_checker (.*);
